[sv/upd_pkg.sv]
// Character codes, status codes, escape phase type and hex decoder for the URL decoder.
package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_SLASH   = 8'h2F;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ESCAPE = 2'd1,
    ST_NOTABS = 2'd2,
    ST_DOTDOT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_NORMAL = 3'b001,
    PH_HI     = 3'b010,
    PH_LO     = 3'b100
  } phase_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      h.value = 4'(c[2:0] + 3'd1) + 4'd8;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

[sv/url_percent_decode_path_check.sv]
// URL percent decoder with absolute-path and dot-dot checks, one URI byte per cycle
// unless out_tready stalls the output. Each accepted byte is held in the input stage,
// its result in the output register. The per-byte state update is one registered step.
// A byte that yields no result only advances the decoder state.
// Reset (rst_n low, synchronous) empties both stages and returns the decoder to its
// start-of-URI state; the byte marked last also returns it there.
module url_percent_decode_path_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tlast,   // in_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] out_byte, [9:8] status, [10] dir_path, rest zero
  output logic        out_tuser,  // byte_valid
  output logic        out_tlast   // path_end
);
  import upd_pkg::*;

  // Input stage
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // Decoder state
  phase_t     phase_r, phase_nxt;
  logic [3:0] high_r, high_nxt;
  logic       seen_r, seen_nxt;
  logic       dot_r, dot_nxt;
  logic       slash_r, slash_nxt;
  status_t    err_r, err_nxt;

  // Output stage
  logic        out_valid_r;
  logic [15:0] out_data_r;
  logic        out_user_r;
  logic        out_last_r;

  logic       advance;
  logic       have;
  logic       emit;
  logic       res;
  logic [7:0] dec;
  status_t    status;
  logic       dir;
  hex_t       hx;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_comb begin
    phase_nxt = phase_r;
    high_nxt  = high_r;
    seen_nxt  = seen_r;
    dot_nxt   = dot_r;
    slash_nxt = slash_r;
    err_nxt   = err_r;
    have      = 1'b0;
    emit      = 1'b0;
    dec       = in_byte_r;
    status    = ST_OK;
    dir       = 1'b0;
    hx        = hex_decode(in_byte_r);

    // After a bad escape every byte is ignored until the last one.
    if (err_r != ST_ESCAPE) begin
      unique case (phase_r)
        PH_NORMAL: begin
          if (in_byte_r == CH_PERCENT) begin
            phase_nxt = PH_HI;
          end else begin
            have = 1'b1;
            dec  = (in_byte_r == CH_PLUS) ? CH_SPACE : in_byte_r;
          end
        end
        PH_HI, PH_LO: begin
          if (!hx.ok) begin
            err_nxt   = ST_ESCAPE;
            phase_nxt = PH_NORMAL;
          end else if (phase_r == PH_HI) begin
            high_nxt  = hx.value;
            phase_nxt = PH_LO;
          end else begin
            dec       = {high_r, hx.value};
            have      = 1'b1;
            phase_nxt = PH_NORMAL;
          end
        end
        default: begin
          phase_nxt = PH_NORMAL;
        end
      endcase
    end

    if (have && err_r == ST_OK) begin
      if (!seen_r) begin
        seen_nxt = 1'b1;
        if (dec != CH_SLASH) begin
          err_nxt = ST_NOTABS;
        end
      end else if (dec == CH_DOT && dot_r) begin
        err_nxt = ST_DOTDOT;
      end
      emit      = (err_nxt == ST_OK);
      dot_nxt   = (dec == CH_DOT);
      slash_nxt = (dec == CH_SLASH);
    end

    if (in_last_r) begin
      if (phase_nxt != PH_NORMAL) begin
        err_nxt = ST_ESCAPE;
      end
      if (err_nxt == ST_OK && !seen_nxt) begin
        err_nxt = ST_NOTABS;
      end
      status = err_nxt;
      dir    = (err_nxt == ST_OK) && slash_nxt;
    end

    res = emit || in_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_NORMAL;
      high_r  <= 4'd0;
      seen_r  <= 1'b0;
      dot_r   <= 1'b0;
      slash_r <= 1'b0;
      err_r   <= ST_OK;
    end else if (advance) begin
      if (in_last_r) begin
        phase_r <= PH_NORMAL;
        high_r  <= 4'd0;
        seen_r  <= 1'b0;
        dot_r   <= 1'b0;
        slash_r <= 1'b0;
        err_r   <= ST_OK;
      end else begin
        phase_r <= phase_nxt;
        high_r  <= high_nxt;
        seen_r  <= seen_nxt;
        dot_r   <= dot_nxt;
        slash_r <= slash_nxt;
        err_r   <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res) begin
      out_data_r <= {5'd0, dir, status, (emit ? dec : 8'd0)};
      out_user_r <= emit;
      out_last_r <= in_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

`ifndef NO_ASSERTIONS
  // A result that does not close the URI always carries a decoded byte.
  a_mid_result_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser)
    else $error("result without byte and without path end");

  // The ends-in-slash flag is only reported on a successful path end.
  a_dir_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[10] |-> out_tlast && out_tdata[9:8] == ST_OK)
    else $error("dir_path set outside a successful path end");

  // A byte emitted together with the path end can only come with status ok.
  a_emit_last_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && out_tlast |-> out_tdata[9:8] == ST_OK)
    else $error("decoded byte emitted on a failing path end");

  // The last byte returns the decoder to its start-of-URI state.
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    advance && in_last_r |=> phase_r == PH_NORMAL && err_r == ST_OK && !seen_r)
    else $error("decoder state not cleared after last byte");
`endif

endmodule
